// File: hw/rtl/rar_pkg.sv
// package for the rational arithmetic reduce block
// shared opcode, status and sequencer state types; no dependencies
`default_nettype none
package rar_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_GCD_INIT,
    S_GCD_DIV,
    S_GCD_NEXT,
    S_RED_N,
    S_RED_D,
    S_CHECK,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/rational_arithmetic_reduce_top.sv
// rational arithmetic unit with gcd reduction, top level
// depends on rar_pkg; one shared multiplier and one shared restoring divider
`default_nettype none
// Takes two signed fractions and an opcode, forms the exact result at double
// width and reduces it to lowest terms with a positive denominator. Status is
// ok, zero denominator, or overflow (zeros given on error). One word is in work
// at a time: in_tready is low from acceptance until the result word has been
// taken. Each word is multiplied out on the shared multiplier, summed for add
// and subtract, reduced by a gcd of repeated remainders and two final divisions,
// and range-checked; a zero denominator goes straight to the output. The time is
// set by the bit-serial restoring divider used for every remainder step and for
// both final divisions.
module rational_arithmetic_reduce_top #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // opcode[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98], zero pad
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // res_num[31:0], res_den[62:32], status[64:63], zero pad
  output logic [71:0]       out_tdata
);
  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * W;
  localparam int CW = $clog2(DW + 1);

  // divider phases
  localparam logic [1:0] PH_GCD = 2'd0;
  localparam logic [1:0] PH_NUM = 2'd1;
  localparam logic [1:0] PH_DEN = 2'd2;

  rar_pkg::state_t state_r, state_nxt;

  logic [1:0]      op_r;
  logic [W-1:0]    an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic            an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic [DW-1:0]   p1_r, p2_r, nm_r, dm_r;
  logic            p1_s_r, p2_s_r, n_s_r;
  logic [DW-1:0]   gx_r, gy_r;
  // divider state
  logic [DW-1:0]   dv_q_r, dv_rem_r, dv_d_r;
  logic [CW-1:0]   dv_cnt_r;
  logic [1:0]      phase_r; // gcd, numerator or denominator division
  logic [31:0]     res_num_r;
  logic [30:0]     res_den_r;
  rar_pkg::status_t status_r;

  // operand decode to sign and magnitude
  function automatic logic [W:0] smag(input logic [31:0] raw);
    logic [W-1:0] u, m;
    u = raw[W-1:0];
    m = u[W-1] ? (~u + 1'b1) : u;
    return {(u[W-1] && (m != '0)), m};
  endfunction

  logic [W:0] an_d, ad_d, bn_d, bd_d;
  assign an_d = smag(in_tdata[33:2]);
  assign ad_d = smag(in_tdata[65:34]);
  assign bn_d = smag(in_tdata[97:66]);
  assign bd_d = smag(in_tdata[129:98]);

  // shared multiplier operand select
  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] mul_p;
  always_comb begin
    mul_a = an_m_r;
    mul_b = bd_m_r;
    unique case (state_r)
      rar_pkg::S_MUL1: begin
        mul_a = an_m_r;
        mul_b = (op_r == rar_pkg::OP_MUL) ? bn_m_r : bd_m_r;
      end
      rar_pkg::S_MUL2: begin
        mul_a = ad_m_r;
        mul_b = (op_r == rar_pkg::OP_DIV) ? bn_m_r :
                (op_r == rar_pkg::OP_MUL) ? bd_m_r : bn_m_r;
      end
      default: begin
        mul_a = ad_m_r;
        mul_b = bd_m_r;
      end
    endcase
  end
  assign mul_p = DW'(mul_a) * DW'(mul_b);

  // one restoring division step
  logic [DW:0]   dv_trial;
  logic [DW-1:0] dv_rem_sh;
  assign dv_rem_sh = {dv_rem_r[DW-2:0], dv_q_r[DW-1]};
  assign dv_trial  = {dv_rem_r[DW-1], dv_rem_sh} - {1'b0, dv_d_r};

  logic sgn_b_eff;
  assign sgn_b_eff = (op_r == rar_pkg::OP_SUB) ? ~bn_s_r : bn_s_r;

  logic [DW-1:0] half, nmax;
  logic          res_neg;
  assign half    = DW'(1) << (W - 1);
  assign res_neg = (nm_r != '0) && n_s_r;
  assign nmax    = res_neg ? half : half - 1'b1;

  // reduced terms at output width
  logic [63:0] nm_ext, dm_ext;
  assign nm_ext = 64'(nm_r);
  assign dm_ext = 64'(dm_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rar_pkg::S_IDLE:     if (in_tvalid) state_nxt = rar_pkg::S_MUL1;
      rar_pkg::S_MUL1: begin
        if (ad_m_r == '0 || bd_m_r == '0 || (op_r == rar_pkg::OP_DIV && bn_m_r == '0))
          state_nxt = rar_pkg::S_OUT;
        else
          state_nxt = rar_pkg::S_MUL2;
      end
      rar_pkg::S_MUL2:     state_nxt = (op_r == rar_pkg::OP_MUL || op_r == rar_pkg::OP_DIV)
                                       ? rar_pkg::S_GCD_INIT : rar_pkg::S_MUL3;
      rar_pkg::S_MUL3:     state_nxt = rar_pkg::S_SUM;
      rar_pkg::S_SUM:      state_nxt = rar_pkg::S_GCD_INIT;
      rar_pkg::S_GCD_INIT: state_nxt = (gy_r == '0) ? rar_pkg::S_RED_N : rar_pkg::S_GCD_DIV;
      rar_pkg::S_GCD_DIV:  if (dv_cnt_r == '0) state_nxt = rar_pkg::S_GCD_NEXT;
      rar_pkg::S_GCD_NEXT: begin
        unique case (phase_r)
          PH_GCD:  state_nxt = (dv_rem_r == '0) ? rar_pkg::S_RED_N : rar_pkg::S_GCD_DIV;
          PH_NUM:  state_nxt = rar_pkg::S_RED_D;
          default: state_nxt = rar_pkg::S_CHECK;
        endcase
      end
      rar_pkg::S_RED_N:    state_nxt = rar_pkg::S_GCD_DIV;
      rar_pkg::S_RED_D:    state_nxt = rar_pkg::S_GCD_DIV;
      rar_pkg::S_CHECK:    state_nxt = rar_pkg::S_OUT;
      rar_pkg::S_OUT:      if (out_tready) state_nxt = rar_pkg::S_IDLE;
      default:             state_nxt = rar_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rar_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      rar_pkg::S_IDLE: if (in_tvalid) begin
        op_r <= in_tdata[1:0];
        {an_s_r, an_m_r} <= an_d;
        {ad_s_r, ad_m_r} <= ad_d;
        {bn_s_r, bn_m_r} <= bn_d;
        {bd_s_r, bd_m_r} <= bd_d;
      end
      rar_pkg::S_MUL1: begin
        p1_r     <= mul_p;
        p1_s_r   <= an_s_r ^ ((op_r == rar_pkg::OP_MUL) ? bn_s_r : bd_s_r);
        res_num_r <= '0;
        res_den_r <= '0;
        status_r  <= rar_pkg::ST_ZERO_DEN;
      end
      rar_pkg::S_MUL2: begin
        if (op_r == rar_pkg::OP_MUL || op_r == rar_pkg::OP_DIV) begin
          nm_r  <= p1_r;
          n_s_r <= (p1_r != '0) &&
                   (p1_s_r ^ ad_s_r ^ ((op_r == rar_pkg::OP_DIV) ? bn_s_r : bd_s_r));
          dm_r  <= mul_p;
          gx_r  <= p1_r;
          gy_r  <= mul_p;
        end else begin
          p2_r   <= mul_p;
          p2_s_r <= sgn_b_eff ^ ad_s_r;
        end
      end
      rar_pkg::S_MUL3: dm_r <= mul_p;
      rar_pkg::S_SUM: begin
        // sign-magnitude add; sign folded with denominator sign ad^bd
        if (p1_s_r == p2_s_r || p1_r == '0 || p2_r == '0) begin
          nm_r  <= p1_r + p2_r;
          n_s_r <= ((p1_r != '0) ? p1_s_r : p2_s_r) ^ ad_s_r ^ bd_s_r;
        end else if (p1_r >= p2_r) begin
          nm_r  <= p1_r - p2_r;
          n_s_r <= p1_s_r ^ ad_s_r ^ bd_s_r;
        end else begin
          nm_r  <= p2_r - p1_r;
          n_s_r <= p2_s_r ^ ad_s_r ^ bd_s_r;
        end
        gx_r <= '0;
        gy_r <= dm_r;
      end
      rar_pkg::S_GCD_INIT: begin
        if (op_r == rar_pkg::OP_ADD || op_r == rar_pkg::OP_SUB) gx_r <= nm_r;
        dv_q_r   <= (op_r == rar_pkg::OP_ADD || op_r == rar_pkg::OP_SUB) ? nm_r : gx_r;
        dv_d_r   <= gy_r;
        dv_rem_r <= '0;
        dv_cnt_r <= CW'(DW);
        phase_r  <= PH_GCD;
        if (gy_r == '0) gy_r <= gx_r; // cannot occur; denominators nonzero
      end
      rar_pkg::S_GCD_DIV: begin
        // one step per cycle while bits remain; idle on the last count
        if (dv_cnt_r != '0) begin
          if (!dv_trial[DW]) begin
            dv_rem_r <= dv_trial[DW-1:0];
            dv_q_r   <= {dv_q_r[DW-2:0], 1'b1};
          end else begin
            dv_rem_r <= dv_rem_sh;
            dv_q_r   <= {dv_q_r[DW-2:0], 1'b0};
          end
          dv_cnt_r <= dv_cnt_r - 1'b1;
        end
      end
      rar_pkg::S_GCD_NEXT: begin
        unique case (phase_r)
          PH_GCD: begin
            gx_r     <= dv_d_r;
            // on a zero remainder the gcd is held in gy
            gy_r     <= (dv_rem_r == '0) ? dv_d_r : dv_rem_r;
            dv_q_r   <= dv_d_r;
            dv_d_r   <= dv_rem_r;
            dv_rem_r <= '0;
            dv_cnt_r <= CW'(DW);
          end
          PH_NUM:  nm_r <= dv_q_r;
          default: dm_r <= dv_q_r;
        endcase
      end
      rar_pkg::S_RED_N: begin
        dv_q_r   <= nm_r;
        dv_d_r   <= gy_r;
        dv_rem_r <= '0;
        dv_cnt_r <= CW'(DW);
        phase_r  <= PH_NUM;
      end
      rar_pkg::S_RED_D: begin
        dv_q_r   <= dm_r;
        dv_d_r   <= gy_r;
        dv_rem_r <= '0;
        dv_cnt_r <= CW'(DW);
        phase_r  <= PH_DEN;
      end
      rar_pkg::S_CHECK: begin
        if (nm_r > nmax || dm_r > half - 1'b1) begin
          status_r  <= rar_pkg::ST_OVERFLOW;
          res_num_r <= '0;
          res_den_r <= '0;
        end else begin
          status_r  <= rar_pkg::ST_OK;
          res_num_r <= res_neg ? 32'(64'd0 - nm_ext) : nm_ext[31:0];
          res_den_r <= dm_ext[30:0];
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == rar_pkg::S_IDLE);
  assign out_tvalid = (state_r == rar_pkg::S_OUT);
  assign out_tdata  = {7'd0, status_r, res_den_r, res_num_r};
endmodule
`default_nettype wire

// File: hw/rtl/rar_checker.sv
// port-level checker for the rational arithmetic reduce top level
// depends on rar_pkg; bound to rational_arithmetic_reduce_top
`default_nettype none
module rar_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [71:0]  out_tdata
);
  // one word in work: never ready while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // errors give zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64:63] != rar_pkg::ST_OK |-> out_tdata[62:0] == '0)
    else $error("nonzero payload on error");

  // ok results have a positive denominator
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64:63] == rar_pkg::ST_OK |-> out_tdata[62:32] != '0)
    else $error("zero denominator on ok");

  // accepted word leaves ready low next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");
endmodule

bind rational_arithmetic_reduce_top rar_checker u_rar_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
